// ===== sv/ycr_pkg.sv =====
// ----------------------------------------------------------------------------
// ycr_pkg: shared types and constants for the YCbCr to RGB converter
// Sampling mode codes, per-pixel sideband and fixed-point reciprocals.
// ----------------------------------------------------------------------------
package ycr_pkg;

  typedef enum logic [1:0] {
    MODE_GRAY = 2'd0,
    MODE_H1V1 = 2'd1,
    MODE_H2V1 = 2'd2,
    MODE_H2V2 = 2'd3
  } mode_t;

  // sideband that travels with each pixel through the datapath
  typedef struct packed {
    logic lower;
    logic done;
    logic last;
  } pix_ctl_t;

  localparam logic [7:0]  CHROMA_ZERO = 8'd128;
  // ceil(2^16 / 10): exact floor(n / 10) for n up to 2048
  localparam logic [12:0] RECIP_TEN   = 13'd6554;
  // ceil(2^9 / 3): exact floor(n / 3) for n up to 128
  localparam logic [7:0]  RECIP_THREE = 8'd171;
  localparam logic signed [10:0] BYTE_MAX = 11'sd255;

  function automatic logic [7:0] clamp_byte(input logic signed [10:0] v);
    logic [7:0] r;
    if (v < 11'sd0) begin
      r = 8'd0;
    end else if (v > BYTE_MAX) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

// ===== sv/ycbcr_to_rgb_subsampled.sv =====
// ----------------------------------------------------------------------------
// ycbcr_to_rgb_subsampled: YCbCr to RGB with chroma upsampling
// Turns one chroma pair plus up to four luma samples into RGB pixels.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): one item = four luma samples, one
//   Cb/Cr pair and a row-done flag. Taken at an edge with in_valid high and
//   in_stall low.
//   Output channel (out_valid / out_stall): one pixel per item, with lower_row,
//   row_done_out and final_of_run (set on the item's last pixel).
//   sampling_mode is written through cfg_wr_en / cfg_wr_data while idle:
//   0 grayscale and 1 chroma 1:1 give one pixel, 2 chroma 2:1 gives two
//   (upper left, upper right), 3 chroma 2:2 gives four (upper pair, then
//   lower pair).
// Flow
//   The first pixel passes the sequencer, chroma stage A, chroma stage B
//   and the output register; the rest follow one per cycle unless the
//   output stalls. An item's pixels share a single pixel lane. The next
//   item is taken in the cycle the current item's last pixel leaves the
//   sequencer, so items run back to back.
// Reset and stall
//   rst (synchronous) empties every stage and sets grayscale. A stall on the
//   output holds the output register; the stages behind it fill and then
//   stall in turn, and nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module ycbcr_to_rgb_subsampled import ycr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] luma_upper_left,
  input  logic [7:0] luma_upper_right,
  input  logic [7:0] luma_lower_left,
  input  logic [7:0] luma_lower_right,
  input  logic [7:0] chroma_blue,
  input  logic [7:0] chroma_red,
  input  logic       row_done_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       lower_row,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic       row_done_out,
  output logic       final_of_run
);

  mode_t sampling_mode;

  // sequencer -> chroma stages
  logic       seq_valid, seq_stall;
  logic [7:0] seq_luma, seq_cb, seq_cr;
  pix_ctl_t   seq_ctl;

  // chroma stages -> mix
  logic       chr_valid, chr_stall;
  logic [7:0] chr_luma;
  pix_ctl_t   chr_ctl;
  logic       chr_neg_r, chr_neg_b;
  logic [7:0] chr_cr16_mag, chr_cb_mag;
  logic [5:0] chr_cb6_mag;

  // mode register; the user must write it only while no item is in flight, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      sampling_mode <= MODE_GRAY;
    end else if (cfg_wr_en) begin
      sampling_mode <= mode_t'(cfg_wr_data);
    end
  end

  // item -> pixels, one per cycle unless stalled; mode captured with the item
  ycr_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .mode             (sampling_mode),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .luma_upper_left  (luma_upper_left),
    .luma_upper_right (luma_upper_right),
    .luma_lower_left  (luma_lower_left),
    .luma_lower_right (luma_lower_right),
    .chroma_blue      (chroma_blue),
    .chroma_red       (chroma_red),
    .row_done_in      (row_done_in),
    .out_valid        (seq_valid),
    .out_stall        (seq_stall),
    .pix_luma         (seq_luma),
    .pix_cb           (seq_cb),
    .pix_cr           (seq_cr),
    .pix_ctl          (seq_ctl)
  );

  // two stages: chroma magnitudes, then reciprocal multiplies
  ycr_chroma u_chroma (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (seq_valid),
    .in_stall   (seq_stall),
    .pix_luma   (seq_luma),
    .pix_cb     (seq_cb),
    .pix_cr     (seq_cr),
    .pix_ctl    (seq_ctl),
    .out_valid  (chr_valid),
    .out_stall  (chr_stall),
    .b_luma     (chr_luma),
    .b_ctl      (chr_ctl),
    .b_neg_r    (chr_neg_r),
    .b_cr16_mag (chr_cr16_mag),
    .b_neg_b    (chr_neg_b),
    .b_cb_mag   (chr_cb_mag),
    .b_cb6_mag  (chr_cb6_mag)
  );

  // sums, clamp and the output register
  ycr_mix u_mix (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (chr_valid),
    .in_stall     (chr_stall),
    .b_luma       (chr_luma),
    .b_ctl        (chr_ctl),
    .b_neg_r      (chr_neg_r),
    .b_cr16_mag   (chr_cr16_mag),
    .b_neg_b      (chr_neg_b),
    .b_cb_mag     (chr_cb_mag),
    .b_cb6_mag    (chr_cb6_mag),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .lower_row    (lower_row),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .row_done_out (row_done_out),
    .final_of_run (final_of_run)
  );

endmodule

// ===== sv/ycr_seq.sv =====
// ----------------------------------------------------------------------------
// ycr_seq: pixel sequencer
// Holds one item and issues its 1, 2 or 4 pixels, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ycr_seq import ycr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  mode_t      mode,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] luma_upper_left,
  input  logic [7:0] luma_upper_right,
  input  logic [7:0] luma_lower_left,
  input  logic [7:0] luma_lower_right,
  input  logic [7:0] chroma_blue,
  input  logic [7:0] chroma_red,
  input  logic       row_done_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] pix_luma,
  output logic [7:0] pix_cb,
  output logic [7:0] pix_cr,
  output pix_ctl_t   pix_ctl
);

  logic       busy;
  logic [1:0] cnt;
  mode_t      item_mode;
  logic [7:0] yul, yur, yll, ylr, cb, cr;
  logic       done;

  logic [1:0] last_idx;
  logic       is_last;
  logic       step;
  logic       take;

  always_comb begin
    unique case (item_mode)
      MODE_GRAY, MODE_H1V1: last_idx = 2'd0;
      MODE_H2V1:            last_idx = 2'd1;
      MODE_H2V2:            last_idx = 2'd3;
      default:              last_idx = 2'd0;
    endcase
  end

  assign is_last  = (cnt == last_idx);
  assign step     = busy && !out_stall;
  assign in_stall = busy && !(step && is_last);
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
    end else if (take) begin
      busy <= 1'b1;
      cnt  <= 2'd0;
    end else if (step) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_mode <= mode;
      yul       <= luma_upper_left;
      yur       <= luma_upper_right;
      yll       <= luma_lower_left;
      ylr       <= luma_lower_right;
      cb        <= chroma_blue;
      cr        <= chroma_red;
      done      <= row_done_in;
    end
  end

  // order: upper-left, upper-right, lower-left, lower-right
  always_comb begin
    unique case (cnt)
      2'd0:    pix_luma = yul;
      2'd1:    pix_luma = yur;
      2'd2:    pix_luma = yll;
      2'd3:    pix_luma = ylr;
      default: pix_luma = yul;
    endcase
  end

  // grayscale: neutral chroma makes every offset zero
  assign pix_cb = (item_mode == MODE_GRAY) ? CHROMA_ZERO : cb;
  assign pix_cr = (item_mode == MODE_GRAY) ? CHROMA_ZERO : cr;

  assign pix_ctl.lower = cnt[1];
  assign pix_ctl.done  = done;
  assign pix_ctl.last  = is_last;
  assign out_valid     = busy;

endmodule

// ===== sv/ycr_chroma.sv =====
// ----------------------------------------------------------------------------
// ycr_chroma: chroma term stages
// Stage A: sign and magnitude of Cb-128, Cr-128.
// Stage B: reciprocal multiplies for |Cr-128|*16/10 and |Cb-128|/3.
// ----------------------------------------------------------------------------
module ycr_chroma import ycr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] pix_luma,
  input  logic [7:0] pix_cb,
  input  logic [7:0] pix_cr,
  input  pix_ctl_t   pix_ctl,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] b_luma,
  output pix_ctl_t   b_ctl,
  output logic       b_neg_r,
  output logic [7:0] b_cr16_mag,
  output logic       b_neg_b,
  output logic [7:0] b_cb_mag,
  output logic [5:0] b_cb6_mag
);

  // stage A
  logic       a_valid;
  logic [7:0] a_luma;
  pix_ctl_t   a_ctl;
  logic       a_neg_r, a_neg_b;
  logic [7:0] a_cr_mag, a_cb_mag;
  // stage B
  logic       b_valid;

  logic       a_stall, b_stall;
  logic [7:0] cr_mag, cb_mag;
  logic [24:0] cr_prod;
  logic [15:0] cb_prod;

  assign b_stall  = b_valid && out_stall;
  assign a_stall  = a_valid && b_stall;
  assign in_stall = a_stall;

  // magnitude of x-128, 0..128
  assign cr_mag = pix_cr[7] ? {1'b0, pix_cr[6:0]} : (8'd128 - pix_cr);
  assign cb_mag = pix_cb[7] ? {1'b0, pix_cb[6:0]} : (8'd128 - pix_cb);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!a_stall) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!a_stall) begin
      a_luma   <= pix_luma;
      a_ctl    <= pix_ctl;
      a_neg_r  <= ~pix_cr[7];
      a_neg_b  <= ~pix_cb[7];
      a_cr_mag <= cr_mag;
      a_cb_mag <= cb_mag;
    end
  end

  assign cr_prod = {a_cr_mag, 4'b0000} * RECIP_TEN;
  assign cb_prod = a_cb_mag * RECIP_THREE;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (!b_stall) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!b_stall) begin
      b_luma     <= a_luma;
      b_ctl      <= a_ctl;
      b_neg_r    <= a_neg_r;
      b_cr16_mag <= cr_prod[23:16];
      b_neg_b    <= a_neg_b;
      b_cb_mag   <= a_cb_mag;
      b_cb6_mag  <= cb_prod[14:9];
    end
  end

  assign out_valid = b_valid;

endmodule

// ===== sv/ycr_mix.sv =====
// ----------------------------------------------------------------------------
// ycr_mix: colour sum, clamp and output register
// Signed chroma terms added to or subtracted from luma, each component clamped to a byte.
// ----------------------------------------------------------------------------
module ycr_mix import ycr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] b_luma,
  input  pix_ctl_t   b_ctl,
  input  logic       b_neg_r,
  input  logic [7:0] b_cr16_mag,
  input  logic       b_neg_b,
  input  logic [7:0] b_cb_mag,
  input  logic [5:0] b_cb6_mag,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       lower_row,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic       row_done_out,
  output logic       final_of_run
);

  logic o_valid;
  logic stall;

  logic signed [10:0] y_s, cr16_s, half_s, cb6_s, cb2_s;
  logic signed [10:0] r_s, g_s, bl_s;

  // truncation toward zero: halve and divide the magnitude, then sign it
  always_comb begin
    y_s    = $signed({3'b000, b_luma});
    cr16_s = b_neg_r ? -$signed({3'b000, b_cr16_mag})
                     :  $signed({3'b000, b_cr16_mag});
    half_s = b_neg_r ? -$signed({4'b0000, b_cr16_mag[7:1]})
                     :  $signed({4'b0000, b_cr16_mag[7:1]});
    cb6_s  = b_neg_b ? -$signed({5'b00000, b_cb6_mag})
                     :  $signed({5'b00000, b_cb6_mag});
    cb2_s  = b_neg_b ? -$signed({2'b00, b_cb_mag, 1'b0})
                     :  $signed({2'b00, b_cb_mag, 1'b0});
    r_s    = y_s + cr16_s;
    g_s    = y_s - (half_s + cb6_s);
    bl_s   = y_s + cb2_s;
  end

  assign stall    = o_valid && out_stall;
  assign in_stall = stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (!stall) begin
      o_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      lower_row    <= b_ctl.lower;
      red          <= clamp_byte(r_s);
      green        <= clamp_byte(g_s);
      blue         <= clamp_byte(bl_s);
      row_done_out <= b_ctl.done;
      final_of_run <= b_ctl.last;
    end
  end

  assign out_valid = o_valid;

endmodule
